>>> sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, register indexes and compare helpers for the 3x3 median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

  // Pixel and configuration widths.
  localparam int unsigned PixW = 8;
  localparam int unsigned CfgW = 12;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegImageWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight = 1'd1;

  // Reset values of the configuration registers.
  localparam logic [CfgW-1:0] ImageWidthRst  = 12'd640;
  localparam logic [CfgW-1:0] ImageHeightRst = 12'd480;
  localparam logic [CfgW-1:0] MinDim         = 12'd3;

  // One window row after sorting its three samples.
  typedef struct packed {
    logic [PixW-1:0] lo;
    logic [PixW-1:0] md;
    logic [PixW-1:0] hi;
  } row_sort_t;

  function automatic logic [PixW-1:0] min8(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PixW-1:0] max8(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Median of three samples.
  function automatic logic [PixW-1:0] mid3(input logic [PixW-1:0] a,
                                           input logic [PixW-1:0] b,
                                           input logic [PixW-1:0] c);
    return max8(min8(a, b), min8(max8(a, b), c));
  endfunction

  // Sort a row of three samples into minimum, median and maximum.
  function automatic row_sort_t sort_row(input logic [PixW-1:0] a,
                                         input logic [PixW-1:0] b,
                                         input logic [PixW-1:0] c);
    row_sort_t s;
    s.lo = min8(min8(a, b), c);
    s.md = mid3(a, b, c);
    s.hi = max8(max8(a, b), c);
    return s;
  endfunction

endpackage

>>> sv/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> sv/median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// Streaming 3x3 median filter for 8-bit grayscale pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (pixel_i, in_valid_i/in_ready_o), one
// beat per pixel, left to right and top to bottom. For every interior pixel
// one beat leaves on the output channel (median_value_o, last_of_frame_o,
// out_valid_o/out_ready_i); border pixels give no beat. last_of_frame_o marks
// the result of the final interior pixel of the frame.
// The line width and frame height are set through the configuration port
// (cfg_index_i, cfg_data_i, cfg_valid_i/cfg_ready_o); the user must write
// them only while the block is idle, which the block itself does not enforce.
// Throughput is one pixel per cycle while the skid register is empty, set
// by the single read and write of each line store per pixel. The median for
// pixel (r-1,c-1) reaches the output register after pixel (r,c) is accepted:
// the line stores are read into stage 1 at acceptance, the sorted rows are
// registered in stage 2, and the merged median is then loaded into the
// output register. When the receiver stalls, a skid register takes one more
// result and in_ready_o drops while it is occupied. Reset clears the counters
// and pipeline, and loads width 640 and height 480; the line stores are not
// cleared, since no result uses an entry not yet written within the frame.
module median_filter_3x3_top import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration port
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  // Pixel input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     pixel_i,
  // Result output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PixW-1:0]     median_value_o,
  output logic                last_of_frame_o
);

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = ($clog2(MAX_WIDTH + 1) > CfgW) ? $clog2(MAX_WIDTH + 1) : CfgW;
  localparam logic [WW-1:0] MaxW = WW'(MAX_WIDTH);

  // Configuration registers; the port never stalls.
  logic [CfgW-1:0] image_width_q, image_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= ImageWidthRst;
      image_height_q <= ImageHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegImageWidth:  image_width_q  <= cfg_data_i;
        RegImageHeight: image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective last column and last row after clamping.
  logic [WW-1:0]   width_ext, width_eff, col_last;
  logic [CfgW-1:0] height_eff, row_last;

  always_comb begin
    width_ext = WW'(image_width_q);
    if (width_ext > MaxW) begin
      width_eff = MaxW;
    end else if (width_ext < WW'(MinDim)) begin
      width_eff = WW'(MinDim);
    end else begin
      width_eff = width_ext;
    end
    col_last   = width_eff - WW'(1);
    height_eff = (image_height_q < MinDim) ? MinDim : image_height_q;
    row_last   = height_eff - CfgW'(1);
  end

  // The whole pipeline moves together while the skid register is empty.
  logic skid_valid_q;
  logic advance;
  logic in_fire;

  assign advance    = !skid_valid_q;
  assign in_ready_o = advance;
  assign in_fire    = in_valid_i && advance;

  // Position counters.
  logic [AddrW-1:0] col_q, col_d;
  logic [CfgW-1:0]  row_q, row_d;
  logic             line_end, frame_end, emit;

  always_comb begin
    line_end  = WW'(col_q) >= col_last;
    frame_end = line_end && (row_q >= row_last);
    emit      = (row_q >= CfgW'(2)) && (col_q >= AddrW'(2));
    col_d     = col_q;
    row_d     = row_q;
    if (in_fire) begin
      if (line_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + CfgW'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: pixel waits for the line store read of its column.
  logic             s1_valid_q;
  logic             s1_emit_q, s1_last_q;
  logic [PixW-1:0]  s1_pixel_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [PixW-1:0]  upper_rdata, middle_rdata;
  logic             store_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pixel_q <= pixel_i;
      s1_addr_q  <= col_q;
      s1_emit_q  <= emit;
      s1_last_q  <= frame_end;
    end
  end

  // Line stores: read at acceptance, written back from stage 1. Successive
  // pixels use different columns, so the read and write never collide.
  assign store_we = advance && s1_valid_q;

  mf3_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_addr_q),
    .wdata_i (middle_rdata),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (upper_rdata)
  );

  mf3_ram #(.Width(PixW), .Depth(MAX_WIDTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_pixel_q),
    .re_i    (in_fire),
    .raddr_i (col_q),
    .rdata_o (middle_rdata)
  );

  // Window columns: entries 0..2 oldest column, 3..5 the next one.
  logic [PixW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (store_we) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= upper_rdata;
      win_q[4] <= middle_rdata;
      win_q[5] <= s1_pixel_q;
    end
  end

  // Stage 2: each row of the window sorted.
  logic      s2_valid_q, s2_last_q;
  row_sort_t s2_top_q, s2_cen_q, s2_bot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      s2_top_q  <= sort_row(win_q[0], win_q[3], upper_rdata);
      s2_cen_q  <= sort_row(win_q[1], win_q[4], middle_rdata);
      s2_bot_q  <= sort_row(win_q[2], win_q[5], s1_pixel_q);
      s2_last_q <= s1_last_q;
    end
  end

  // Merge of the sorted rows into the median.
  logic [PixW-1:0] lo_max, hi_min, md_mid, median;

  always_comb begin
    lo_max = max8(max8(s2_top_q.lo, s2_cen_q.lo), s2_bot_q.lo);
    hi_min = min8(min8(s2_top_q.hi, s2_cen_q.hi), s2_bot_q.hi);
    md_mid = mid3(s2_top_q.md, s2_cen_q.md, s2_bot_q.md);
    median = mid3(lo_max, md_mid, hi_min);
  end

  // Output register with one skid entry behind it.
  logic            out_valid_q, out_last_q, skid_last_q;
  logic [PixW-1:0] out_value_q, skid_value_q;
  logic            out_fire, push, to_skid, load_out;

  assign out_fire = out_valid_q && out_ready_i;
  assign push     = advance && s2_valid_q;
  assign to_skid  = push && out_valid_q && !out_ready_i;
  assign load_out = (push && !to_skid) || (skid_valid_q && out_fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
      if (to_skid) begin
        skid_valid_q <= 1'b1;
      end else if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (to_skid) begin
      skid_value_q <= median;
      skid_last_q  <= s2_last_q;
    end
    if (skid_valid_q && out_fire) begin
      out_value_q <= skid_value_q;
      out_last_q  <= skid_last_q;
    end else if (push && !to_skid) begin
      out_value_q <= median;
      out_last_q  <= s2_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign median_value_o  = out_value_q;
  assign last_of_frame_o = out_last_q;

endmodule
